// ----- rtl/reversible_ring_deque_unit_assert.svh -----
// assertion macros for the reversible ring deque unit
`ifndef REVERSIBLE_RING_DEQUE_UNIT_ASSERT_SVH
`define REVERSIBLE_RING_DEQUE_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define RRDU_ASSERT_IMPLY(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked on every rising edge outside reset
`define RRDU_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/rrd_pkg.sv -----
// shared constants for the reversible ring deque unit
package rrd_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int VALUE_W       = 32;
    localparam int REQ_W         = 3;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TOGGLE     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;

endpackage

// ----- rtl/reversible_ring_deque_unit.sv -----
// top level of the reversible ring deque unit
//
//  channel  dir  tdata                                   tuser
//  s_axis   in   push_value                              req_type
//  m_axis   out  out_value, empty_error, full_error,     -
//                item_count, reversed
//
// an item that is not a successful remove has its result registered on acceptance,
// shown from the next cycle; a successful remove goes through the address cycle, then the ram read cycle
// the next item is taken once no read cycle is pending and the result register is empty or being taken
// reset clears pointers, count, flag and control; stored values are kept and
// a slot is only ever read after a push has written it, so there is no clearing pass
// a stall on m_axis holds the result and blocks further items on s_axis
`include "reversible_ring_deque_unit_assert.svh"

module reversible_ring_deque_unit #(
    parameter int DEPTH = rrd_pkg::DEPTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rrd_pkg::VALUE_W-1:0]   s_tdata,   // push_value
    input  logic [rrd_pkg::REQ_W-1:0]     s_tuser,   // req_type
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_value, empty_error, full_error, item_count, reversed, zero fill
    output logic [((rrd_pkg::VALUE_W + 3 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = rrd_pkg::VALUE_W;
    localparam int RES_W = VAL_W + 3 + CNT_W;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic [0:0] {ST_IDLE, ST_READ} state_t;

    state_t             state_reg;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               rev_reg, rev_next;

    logic               out_valid_reg;
    logic [VAL_W-1:0]   out_value_reg;
    logic               empty_err_reg, full_err_reg;
    logic [CNT_W-1:0]   out_count_reg;
    logic               out_rev_reg;

    logic               accept;
    logic               go_read;
    logic               empty_err, full_err;
    logic               wr_en, rd_en;
    logic [PTR_W-1:0]   wr_addr, rd_addr;
    logic [VAL_W-1:0]   rd_data;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    // one item in flight: wait for the read cycle and for a free result register
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // request decode and next pointer state
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        empty_err  = 1'b0;
        full_err   = 1'b0;
        go_read    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        rd_en      = 1'b0;
        rd_addr    = tail_reg;
        case (s_tuser)
            rrd_pkg::REQ_PUSH_BACK:
            begin
                if (count_reg == CNT_FULL)
                begin
                    full_err = 1'b1;
                end
                else
                begin
                    tail_next  = ptr_inc(tail_reg);
                    wr_en      = accept;
                    wr_addr    = tail_next;
                    count_next = count_reg + 1'b1;
                end
            end
            rrd_pkg::REQ_PUSH_FRONT:
            begin
                if (count_reg == CNT_FULL)
                begin
                    full_err = 1'b1;
                end
                else
                begin
                    wr_en      = accept;
                    wr_addr    = head_reg;
                    head_next  = ptr_dec(head_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            rrd_pkg::REQ_TOGGLE:
            begin
                rev_next = ~rev_reg;
            end
            rrd_pkg::REQ_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    empty_err = 1'b1;
                end
                else
                begin
                    // logical front is the physical back while reversed
                    go_read    = 1'b1;
                    rd_en      = accept;
                    count_next = count_reg - 1'b1;
                    if (rev_reg)
                    begin
                        rd_addr   = tail_reg;
                        tail_next = ptr_dec(tail_reg);
                    end
                    else
                    begin
                        head_next = ptr_inc(head_reg);
                        rd_addr   = head_next;
                    end
                end
            end
            rrd_pkg::REQ_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
                rev_next   = 1'b0;
            end
            default:
            begin
                // unused codes leave everything as it is
            end
        endcase
    end

    rrd_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // state, pointers and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        head_reg  <= head_next;
                        tail_reg  <= tail_next;
                        count_reg <= count_next;
                        rev_reg   <= rev_next;
                        if (go_read)
                        begin
                            state_reg <= ST_READ;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_READ:
                begin
                    // ram data is back, result register is known to be free
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            out_value_reg <= rd_data;
            empty_err_reg <= 1'b0;
            full_err_reg  <= 1'b0;
            out_count_reg <= count_reg;
            out_rev_reg   <= rev_reg;
        end
        else if (accept && !go_read)
        begin
            out_value_reg <= '0;
            empty_err_reg <= empty_err;
            full_err_reg  <= full_err;
            out_count_reg <= count_next;
            out_rev_reg   <= rev_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_rev_reg, out_count_reg, full_err_reg, empty_err_reg,
                              out_value_reg});

    // the count never passes the capacity
    `RRDU_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_FULL)
    // an empty deque has both pointers on the same slot
    `RRDU_ASSERT_IMPLY(a_empty_ptrs, count_reg == '0, head_reg == tail_reg)
    // the read cycle always finds the result register free
    `RRDU_ASSERT_IMPLY(a_read_free, state_reg == ST_READ, !out_valid_reg)
    // a successful remove is followed by the read cycle
    `RRDU_ASSERT_NEXT(a_remove_read, accept && go_read, state_reg == ST_READ)
    // any other accepted item shows its result on the next cycle
    `RRDU_ASSERT_NEXT(a_direct_result, accept && !go_read, out_valid_reg)

endmodule

// ----- rtl/rrd_ram.sv -----
// generic simple dual-port ram with registered read
module rrd_ram #(
    parameter int WIDTH = rrd_pkg::VALUE_W,
    parameter int DEPTH = rrd_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
